[rtl/legendre_poly_value_and_slope_assert.svh]
// assertion macros for the legendre value and slope block
// no dependencies, included by the top level
`ifndef LEGENDRE_POLY_VALUE_AND_SLOPE_ASSERT_SVH
`define LEGENDRE_POLY_VALUE_AND_SLOPE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LPVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpvs assertion failed");

// next-cycle implication, disabled in reset
`define LPVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpvs assertion failed");

`endif

[rtl/lpvs_pkg.sv]
// package for the legendre value and slope block: field widths, fixed point format,
// sequencer state and phase types; no dependencies
`timescale 1ns / 1ps

package lpvs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ORDER_W   = 4;
	localparam int POINT_W   = 18;
	localparam int VALUE_W   = 18;
	localparam int SLOPE_W   = 24;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_LAST
	} state_t;

	// one product of the shared multiplier per phase
	typedef enum logic [2:0] {
		PH_PX,
		PH_TC1,
		PH_PC2,
		PH_DX,
		PH_UC1,
		PH_DC2
	} phase_t;

endpackage

[rtl/legendre_poly_value_and_slope.sv]
// after accept the sequencer runs one recurrence step for each degree from 2 to n,
// then a last state that registers the result; busy holds off new commands until then
// each recurrence step runs six rounded products through one shared multiplier
// the result beat shows on value/slope with done for one cycle; the receiver cannot stall
// arst_n clears the sequencer and the done strobe; datapath registers are not reset
`timescale 1ns / 1ps
`include "legendre_poly_value_and_slope_assert.svh"

module legendre_poly_value_and_slope
	import lpvs_pkg::*;
#(
	parameter int MAX_DEGREE = 15
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [ORDER_W-1:0]         order,
	input  logic signed [POINT_W-1:0]  point,
	output logic                       done,
	output logic signed [VALUE_W-1:0]  value,
	output logic signed [SLOPE_W-1:0]  slope
);

	localparam longint ONE       = longint'(1) << FRAC_BITS;
	localparam longint SLOPE_LIM = longint'((MAX_DEGREE * (MAX_DEGREE + 1)) / 2) << FRAC_BITS;
	localparam int     DW        = $clog2(SLOPE_LIM + ONE + 1) + 1;
	localparam int     AW        = DW + 2;
	localparam int     AMW       = DW - 1;
	localparam int     CW        = FRAC_BITS + 1;
	localparam int     VW        = FRAC_BITS + 2;
	localparam int     PMW       = AMW + CW;
	localparam int     KW        = $clog2(MAX_DEGREE + 1);
	localparam longint HALF      = longint'(1) << (FRAC_BITS - 1);

	// coefficient tables, c1 = (2k-1)/k and c2 = (k-1)/k rounded half up
	logic [CW-1:0] c1_tab [MAX_DEGREE+1];
	logic [CW-1:0] c2_tab [MAX_DEGREE+1];

	for (genvar gi = 0; gi <= MAX_DEGREE; gi++) begin : g_coef
		localparam longint KD = (gi < 2) ? 2 : gi;
		localparam longint C1 = (((2 * KD - 1) << FRAC_BITS) + KD / 2) / KD;
		localparam longint C2 = (((KD - 1) << FRAC_BITS) + KD / 2) / KD;
		assign c1_tab[gi] = CW'(C1);
		assign c2_tab[gi] = CW'(C2);
	end

	function automatic logic signed [VW-1:0] clamp_value(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] lim;
		lim = AW'(ONE);
		if (v > lim) begin
			return VW'(lim);
		end else if (v < -lim) begin
			return VW'(-lim);
		end
		return VW'(v);
	endfunction

	function automatic logic signed [DW-1:0] clamp_slope(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] lim;
		lim = AW'(SLOPE_LIM);
		if (v > lim) begin
			return DW'(lim);
		end else if (v < -lim) begin
			return DW'(-lim);
		end
		return DW'(v);
	endfunction

	state_t state_q, state_d;
	phase_t ph_q, ph_d;
	logic   accept;
	logic   done_q;

	logic [KW-1:0]        k_q, n_q, n_in;
	logic signed [VW-1:0] x_q, x_in;
	logic signed [VW-1:0] p0_q, p1_q, pn_q;
	logic signed [DW-1:0] d0_q, d1_q, t_q;
	logic signed [AW-1:0] acc_q, diff;
	logic signed [VW-1:0] value_q;
	logic signed [SLOPE_W-1:0] slope_q;

	// shared multiplier operands and rounded product
	logic signed [DW-1:0] a_op;
	logic signed [VW-1:0] b_op;
	logic                 a_neg, b_neg;
	logic [AMW-1:0]       a_mag;
	logic [CW-1:0]        b_mag;
	logic [PMW-1:0]       pm;
	logic [PMW:0]         pr;
	logic [DW:0]          rm;
	logic signed [AW-1:0] prod;

	assign accept = start && (state_q == ST_IDLE);

	always_comb begin
		if (int'(order) > MAX_DEGREE) begin
			n_in = KW'(MAX_DEGREE);
		end else begin
			n_in = KW'(order);
		end
		if (point > VW'(ONE)) begin
			x_in = VW'(ONE);
		end else if (point < -VW'(ONE)) begin
			x_in = -VW'(ONE);
		end else begin
			x_in = point;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ph_q    <= PH_PX;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ph_d    = PH_PX;
					state_d = (n_in <= KW'(1)) ? ST_LAST : ST_STEP;
				end
			end
			ST_STEP: begin
				unique case (ph_q)
					PH_PX:  ph_d = PH_TC1;
					PH_TC1: ph_d = PH_PC2;
					PH_PC2: ph_d = PH_DX;
					PH_DX:  ph_d = PH_UC1;
					PH_UC1: ph_d = PH_DC2;
					PH_DC2: begin
						ph_d = PH_PX;
						if (k_q == n_q) begin
							state_d = ST_LAST;
						end
					end
					default: ph_d = PH_PX;
				endcase
			end
			ST_LAST: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		unique case (ph_q) inside
			PH_PX: begin
				a_op = DW'(p1_q);
				b_op = x_q;
			end
			PH_TC1, PH_UC1: begin
				a_op = t_q;
				b_op = VW'({1'b0, c1_tab[k_q]});
			end
			PH_PC2: begin
				a_op = DW'(p0_q);
				b_op = VW'({1'b0, c2_tab[k_q]});
			end
			PH_DX: begin
				a_op = d1_q;
				b_op = x_q;
			end
			PH_DC2: begin
				a_op = d0_q;
				b_op = VW'({1'b0, c2_tab[k_q]});
			end
			default: begin
				a_op = d0_q;
				b_op = x_q;
			end
		endcase
	end

	// sign-magnitude product, rounded to nearest with ties away from zero
	always_comb begin
		a_neg = a_op[DW-1];
		b_neg = b_op[VW-1];
		a_mag = AMW'(a_neg ? -a_op : a_op);
		b_mag = CW'(b_neg ? -b_op : b_op);
		pm    = PMW'(a_mag) * PMW'(b_mag);
		pr    = (PMW+1)'(pm) + (PMW+1)'(HALF);
		rm    = pr[PMW:FRAC_BITS];
		prod  = (a_neg ^ b_neg) ? -AW'({1'b0, rm}) : AW'({1'b0, rm});
		diff  = acc_q - prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= (state_q == ST_LAST);
			if (accept) begin
				k_q <= KW'(2);
			end else if (state_q == ST_STEP && ph_q == PH_DC2) begin
				k_q <= k_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q  <= n_in;
			x_q  <= x_in;
			p0_q <= VW'(ONE);
			p1_q <= x_in;
			d0_q <= '0;
			d1_q <= DW'(ONE);
		end else if (state_q == ST_STEP) begin
			unique case (ph_q)
				PH_PX:  t_q   <= DW'(prod);
				PH_TC1: acc_q <= prod;
				PH_PC2: pn_q  <= clamp_value(diff);
				PH_DX:  t_q   <= DW'(prod + AW'(p1_q));
				PH_UC1: acc_q <= prod;
				PH_DC2: begin
					p0_q <= p1_q;
					p1_q <= pn_q;
					d0_q <= d1_q;
					d1_q <= clamp_slope(diff);
				end
				default: acc_q <= prod;
			endcase
		end
		if (state_q == ST_LAST) begin
			if (n_q == '0) begin
				value_q <= VW'(ONE);
				slope_q <= '0;
			end else begin
				value_q <= p1_q;
				slope_q <= SLOPE_W'(d1_q);
			end
		end
	end

	assign done  = done_q;
	assign value = VALUE_W'(value_q);
	assign slope = slope_q;

	`LPVS_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`LPVS_ASSERT_NEXT(a_last_done, clk, arst_n, state_q == ST_LAST, done && !busy)
	`LPVS_ASSERT_NOW(a_step_range, clk, arst_n, state_q == ST_STEP, k_q >= KW'(2) && k_q <= n_q)
	`LPVS_ASSERT_NOW(a_value_range, clk, arst_n, done, value <= VW'(ONE) && value >= -VW'(ONE))

endmodule

[dv/legendre_poly_value_and_slope_checker.sv]
// checker for the legendre value and slope block: predicts P_n(x) and P'_n(x) for every
// accepted command beat and compares each done beat against the oldest prediction
// depends on lpvs_pkg for field widths and the fixed point format
`timescale 1ns / 1ps

module legendre_poly_value_and_slope_checker
	import lpvs_pkg::*;
#(
	parameter int MAX_DEGREE = 15
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [ORDER_W-1:0]        order,
	input  logic signed [POINT_W-1:0] point,
	input  logic                      done,
	input  logic signed [VALUE_W-1:0] value,
	input  logic signed [SLOPE_W-1:0] slope,
	output int                        errors,
	output int                        pending
);

	localparam longint ONE_FX    = longint'(1) << FRAC_BITS;
	localparam longint HALF_LSB  = longint'(1) << (FRAC_BITS - 1);
	localparam longint SLOPE_LIM = longint'((MAX_DEGREE * (MAX_DEGREE + 1)) / 2) << FRAC_BITS;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic signed [SLOPE_W-1:0] slope;
	} poly_result_t;

	poly_result_t poly_q[$];

	function automatic longint clamp_sym(longint v, longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// product scaled back by FRAC_BITS, rounded to nearest, ties away from zero
	function automatic longint fx_mul(longint a, longint b);
		bit     neg;
		longint ma;
		longint mb;
		longint mag;
		neg = (a < 0) != (b < 0);
		ma  = (a < 0) ? -a : a;
		mb  = (b < 0) ? -b : b;
		mag = (ma * mb + HALF_LSB) >> FRAC_BITS;
		return neg ? -mag : mag;
	endfunction

	function automatic longint recur_coef(longint num, longint den);
		return ((num << FRAC_BITS) + den / 2) / den;
	endfunction

	function automatic poly_result_t legendre_eval(logic [ORDER_W-1:0] ord,
			logic signed [POINT_W-1:0] pt);
		int           n;
		longint       x;
		longint       p0;
		longint       p1;
		longint       d0;
		longint       d1;
		longint       pn;
		longint       dn;
		longint       c1;
		longint       c2;
		poly_result_t r;
		n = int'(ord);
		if (n > MAX_DEGREE)
			n = MAX_DEGREE;
		x  = clamp_sym(longint'(pt), ONE_FX);
		p0 = ONE_FX;
		d0 = 0;
		p1 = x;
		d1 = ONE_FX;
		if (n == 0) begin
			p1 = p0;
			d1 = d0;
		end else begin
			for (int k = 2; k <= n; k++) begin
				c1 = recur_coef(2 * k - 1, k);
				c2 = recur_coef(k - 1, k);
				pn = fx_mul(fx_mul(p1, x), c1) - fx_mul(p0, c2);
				dn = fx_mul(fx_mul(d1, x) + p1, c1) - fx_mul(d0, c2);
				p0 = p1;
				p1 = clamp_sym(pn, ONE_FX);
				d0 = d1;
				d1 = clamp_sym(dn, SLOPE_LIM);
			end
		end
		p1 = clamp_sym(p1, ONE_FX);
		d1 = clamp_sym(d1, SLOPE_LIM);
		r.value = p1[VALUE_W-1:0];
		r.slope = d1[SLOPE_W-1:0];
		return r;
	endfunction

	initial begin
		errors  = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		poly_result_t exp_res;
		if (arst_n) begin
			// result beat first: it always belongs to an older command
			if (done) begin
				if (poly_q.size() == 0) begin
					$error("result beat with no prediction waiting: value %0d slope %0d",
						value, slope);
					errors++;
				end else begin
					exp_res = poly_q.pop_front();
					if (value !== exp_res.value) begin
						$error("value mismatch: expected %0d, actual %0d",
							exp_res.value, value);
						errors++;
					end
					if (slope !== exp_res.slope) begin
						$error("slope mismatch: expected %0d, actual %0d",
							exp_res.slope, slope);
						errors++;
					end
				end
			end
			if (start && !busy)
				poly_q.push_back(legendre_eval(order, point));
			pending = poly_q.size();
		end
	end

endmodule

[dv/tb_legendre_poly_value_and_slope.sv]
// testbench top for the legendre value and slope block: directed corner commands, then
// random commands with random gaps; the checker module predicts and compares
// depends on lpvs_pkg, the block and legendre_poly_value_and_slope_checker
`timescale 1ns / 1ps

module tb_legendre_poly_value_and_slope
	import lpvs_pkg::*;
();

	localparam int MAX_DEGREE  = 15;
	localparam int RAND_ITEMS  = 1650;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 100;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic [ORDER_W-1:0]        order;
	logic signed [POINT_W-1:0] point;
	logic                      done;
	logic signed [VALUE_W-1:0] value;
	logic signed [SLOPE_W-1:0] slope;
	int                        errors;
	int                        pending;
	int                        idle_cycles;

	legendre_poly_value_and_slope #(
		.MAX_DEGREE(MAX_DEGREE)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.order (order),
		.point (point),
		.done  (done),
		.value (value),
		.slope (slope)
	);

	legendre_poly_value_and_slope_checker #(
		.MAX_DEGREE(MAX_DEGREE)
	) chk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.order  (order),
		.point  (point),
		.done   (done),
		.value  (value),
		.slope  (slope),
		.errors (errors),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// called at a falling edge; returns at a falling edge after the beat and its gap
	task automatic send_cmd(input logic [ORDER_W-1:0] ord, input logic signed [POINT_W-1:0] pt);
		int roll;
		int gap;
		order <= ord;
		point <= pt;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
		roll = $urandom_range(0, 99);
		if (roll < 40)
			gap = 0;
		else if (roll < 85)
			gap = $urandom_range(1, 3);
		else if (roll < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			start <= 1'b0;
			order <= ORDER_W'($urandom());
			point <= POINT_W'($urandom());
			repeat (gap) @(negedge clk);
		end
	endtask

	initial begin
		int                        roll;
		logic signed [POINT_W-1:0] pt;
		logic signed [POINT_W-1:0] corner_pts[8];
		arst_n = 1'b0;
		start  = 1'b0;
		order  = '0;
		point  = '0;
		corner_pts[0] = -18'sd65536;
		corner_pts[1] = 18'sd65536;
		corner_pts[2] = 18'sd0;
		corner_pts[3] = 18'sd131071;
		corner_pts[4] = -18'sd131072;
		corner_pts[5] = 18'sd32768;
		corner_pts[6] = -18'sd65537;
		corner_pts[7] = 18'sd1;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// every degree, points at the ends, zero and beyond the range
		for (int d = 0; d <= 15; d++)
			send_cmd(ORDER_W'(d), corner_pts[d % 8]);
		send_cmd(4'd15, 18'sd65536);
		send_cmd(4'd15, -18'sd65536);
		send_cmd(4'd15, 18'sd131071);
		send_cmd(4'd14, -18'sd131072);
		send_cmd(4'd1, 18'sd65537);
		send_cmd(4'd0, -18'sd131072);
		send_cmd(4'd2, 18'sd0);
		send_cmd(4'd3, -18'sd1);
		send_cmd(4'd13, 18'sd65535);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 80)
				pt = POINT_W'(int'($urandom_range(0, 131072)) - 65536);
			else if (roll < 86)
				pt = corner_pts[$urandom_range(0, 2)];
			else
				pt = POINT_W'($urandom());
			send_cmd(ORDER_W'($urandom_range(0, 15)), pt);
		end
		start <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
